// ===== sv/bsfa_pkg.sv =====
// Shared types and constants for the blink sequence fade alpha block.
// No dependencies; used by the interfaces, the divider and the top level.
`default_nettype none

package bsfa_pkg;

    localparam int TIME_W    = 48;
    localparam int TSUM_W    = 49;
    localparam int STEP_W    = 6;
    localparam int ALPHA_W   = 8;
    localparam int FADE_W    = 17;
    localparam int SCALE_W   = FADE_W + ALPHA_W;
    localparam int CFG_IDX_W = 3;
    localparam int PAIR_REGS = 4;

    localparam logic [CFG_IDX_W-1:0] REG_PAIR_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_DELAY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_ZERO   = 3'd2;

    localparam logic [ALPHA_W-1:0] FULL_ALPHA = 8'd255;
    localparam logic [ALPHA_W-1:0] ZERO_ALPHA = 8'd0;

    localparam logic [FADE_W-1:0] FADE_MAX = 17'd100000;
    localparam logic [FADE_W-1:0] FADE_MIN = 17'd100;
    localparam logic [31:0]       OFF_SAT  = 32'd1000000;

    localparam int              RECIP_W  = 20;
    localparam logic [RECIP_W-1:0] RECIP10 = 20'hCCCCD;
    localparam int              RECIP_SH = 23;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// ===== sv/bsfa_in_if.sv =====
// Input channel: one item carries a time in microseconds.
// Depends on bsfa_pkg.
`default_nettype none

interface bsfa_in_if;
    logic                          valid;
    logic                          ready;
    logic [bsfa_pkg::TIME_W-1:0]   time_us;

    modport source (output valid, output time_us, input ready);
    modport sink   (input valid, input time_us, output ready);
endinterface

`default_nettype wire

// ===== sv/bsfa_out_if.sv =====
// Output channel: one item carries alpha and the visible flag.
// Depends on bsfa_pkg.
`default_nettype none

interface bsfa_out_if;
    logic                          valid;
    logic                          ready;
    logic [bsfa_pkg::ALPHA_W-1:0]  alpha;
    logic                          visible;

    modport source (output valid, output alpha, output visible, input ready);
    modport sink   (input valid, input alpha, input visible, output ready);
endinterface

`default_nettype wire

// ===== sv/bsfa_div.sv =====
// Shared restoring divider, one quotient bit per cycle, registered results.
// Depends on bsfa_pkg for the request and status structs.
`default_nettype none

module bsfa_div #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 28,
    parameter int QUO_W = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bsfa_pkg::t_div_req   i_req,
    input  logic [NUM_W-1:0]     i_num,
    input  logic [DEN_W-1:0]     i_den,
    output bsfa_pkg::t_div_stat  o_stat,
    output logic [DEN_W-1:0]     o_rem,
    output logic [QUO_W-1:0]     o_quo
);

    logic [NUM_W-1:0]            r_num;
    logic [DEN_W-1:0]            r_den;
    logic [DEN_W-1:0]            r_rem;
    logic [QUO_W-1:0]            r_quo;
    logic [bsfa_pkg::STEP_W-1:0] r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_num[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = trial >= {1'b0, r_den};
        n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == bsfa_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= n_rem;
            r_quo <= {r_quo[QUO_W-2:0], ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;
    assign o_quo       = r_quo;

endmodule

`default_nettype wire

// ===== sv/blink_sequence_fade_alpha.sv =====
// Blink pattern generator with smoothed edges: top level, sequencer and config.
// Depends on bsfa_pkg, bsfa_in_if, bsfa_out_if and bsfa_div.
//
// Usage: i_in takes one item (time_us) at a time; o_out returns exactly one
// item (alpha, visible) for each. Config registers are written through
// i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle; index 0 is the
// pair count, 1 the start delay, 2 to 5 the four on/off pairs.
// The modulo runs 49 steps and the fade scaling 25 steps on one shared
// bit-serial divider; the phase walk takes one pair at a time, in an on step
// and an off step, on one shared adder.
// The block takes a new item only while its sequencer is idle, so it takes no
// new item before the last result is in the output register; a finished
// result sits in the output register, so the next item can start while the
// receiver stalls. A stalled result holds the sequencer in its final step until
// o_out.ready. Reset clears all config registers to zero (steady light) and
// empties the output register; no clearing pass is needed.
`default_nettype none

module blink_sequence_fade_alpha #(
    parameter int MAX_PAIRS     = 4,
    parameter int DURATION_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    bsfa_in_if.sink                             i_in,
    bsfa_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [bsfa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [2*DURATION_BITS-1:0]          i_cfg_data
);

    localparam int PW   = 2 * DURATION_BITS;
    localparam int TW   = DURATION_BITS + 1 + $clog2(MAX_PAIRS);
    localparam int DVW  = (TW > bsfa_pkg::FADE_W) ? TW : bsfa_pkg::FADE_W;
    localparam int KW   = $clog2(MAX_PAIRS + 1);
    localparam int IW   = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int OW   = (DURATION_BITS > bsfa_pkg::RECIP_W) ? DURATION_BITS
                                                              : bsfa_pkg::RECIP_W;
    localparam int PRW  = 2 * bsfa_pkg::RECIP_W;

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_SUM_ON   = 14'b00000000000010,
        S_SUM_OFF  = 14'b00000000000100,
        S_CHK      = 14'b00000000001000,
        S_MOD      = 14'b00000000010000,
        S_SRCH_ON  = 14'b00000000100000,
        S_SRCH_OFF = 14'b00000001000000,
        S_DIST     = 14'b00000010000000,
        S_FADE     = 14'b00000100000000,
        S_FIX      = 14'b00001000000000,
        S_CMP      = 14'b00010000000000,
        S_SCALE    = 14'b00100000000000,
        S_DIV      = 14'b01000000000000,
        S_OUT      = 14'b10000000000000
    } t_state;

    // config
    logic [2:0]               r_pair_count;
    logic [DURATION_BITS-1:0] r_start_delay;
    logic [PW-1:0]            r_pair [MAX_PAIRS];

    // sequencer
    t_state                            r_state, n_state;
    logic [KW-1:0]                     r_k;
    logic [KW-1:0]                     r_n;
    logic [bsfa_pkg::TSUM_W-1:0]       r_tsum;
    logic [TW-1:0]                     r_total;
    logic [TW-1:0]                     r_local;
    logic [TW-1:0]                     r_edge;
    logic [TW-1:0]                     r_e1;
    logic [TW-1:0]                     r_d0;
    logic [TW-1:0]                     r_d1;
    logic [TW-1:0]                     r_d;
    logic [PRW-1:0]                    r_prod;
    logic                              r_big;
    logic [bsfa_pkg::FADE_W-1:0]       r_fade;
    logic [bsfa_pkg::FADE_W-1:0]       r_x;
    logic [bsfa_pkg::ALPHA_W-1:0]      r_res;

    // output register
    logic                              r_out_valid;
    logic [bsfa_pkg::ALPHA_W-1:0]      r_alpha;
    logic                              r_vis;

    logic                              in_acc;
    logic                              out_load;
    logic [KW-1:0]                     n_sel;
    logic [DURATION_BITS-1:0]          cur_on;
    logic [DURATION_BITS-1:0]          cur_off;
    logic [TW-1:0]                     add_a;
    logic [TW-1:0]                     add_b;
    logic [TW-1:0]                     add_sum;
    logic                              last;
    logic [OW-1:0]                     off_ext;
    logic [bsfa_pkg::FADE_W-1:0]       q10;
    logic [DVW-1:0]                    fade_diff;
    logic                              d_ge_fade;
    logic [bsfa_pkg::SCALE_W-1:0]      scale;

    bsfa_pkg::t_div_req                div_req;
    bsfa_pkg::t_div_stat               div_stat;
    logic [bsfa_pkg::TSUM_W-1:0]       div_num;
    logic [DVW-1:0]                    div_den;
    logic [DVW-1:0]                    div_rem;
    logic [bsfa_pkg::ALPHA_W-1:0]      div_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_count  <= '0;
            r_start_delay <= '0;
            for (int j = 0; j < MAX_PAIRS; j++) begin
                r_pair[j] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == bsfa_pkg::REG_PAIR_COUNT) begin
                r_pair_count <= i_cfg_data[2:0];
            end
            if (i_cfg_idx == bsfa_pkg::REG_START_DELAY) begin
                r_start_delay <= i_cfg_data[DURATION_BITS-1:0];
            end
            for (int j = 0; j < MAX_PAIRS; j++) begin
                if (j < bsfa_pkg::PAIR_REGS &&
                    i_cfg_idx == bsfa_pkg::REG_PAIR_ZERO + bsfa_pkg::CFG_IDX_W'(j)) begin
                    r_pair[j] <= i_cfg_data;
                end
            end
        end
    end

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_load = r_state == S_OUT && (!r_out_valid || o_out.ready);

    always_comb begin
        n_sel   = (4'(r_pair_count) > 4'(MAX_PAIRS)) ? KW'(MAX_PAIRS) : KW'(r_pair_count);
        cur_on  = r_pair[r_k[IW-1:0]][DURATION_BITS-1:0];
        cur_off = r_pair[r_k[IW-1:0]][PW-1:DURATION_BITS];
        add_a   = (r_state == S_SUM_ON || r_state == S_SUM_OFF) ? r_total : r_edge;
        add_b   = (r_state == S_SUM_ON || r_state == S_SRCH_ON) ? TW'(cur_on)
                                                                : TW'(cur_off);
        add_sum = add_a + add_b;
        last    = (r_k + KW'(1)) == r_n;
        off_ext = OW'(cur_off);
        q10     = r_prod[bsfa_pkg::RECIP_SH +: bsfa_pkg::FADE_W];
        fade_diff = DVW'(r_fade) - DVW'(r_d);
        d_ge_fade = DVW'(r_d) >= DVW'(r_fade);
        scale   = {r_x, bsfa_pkg::ALPHA_W'(0)} - bsfa_pkg::SCALE_W'(r_x);
    end

    always_comb begin
        div_req.start = (r_state == S_CHK && r_total != '0) || r_state == S_SCALE;
        if (r_state == S_SCALE) begin
            div_req.steps = bsfa_pkg::STEP_W'(bsfa_pkg::SCALE_W);
            div_num       = bsfa_pkg::TSUM_W'(scale)
                            << (bsfa_pkg::TSUM_W - bsfa_pkg::SCALE_W);
            div_den       = DVW'(r_fade);
        end else begin
            div_req.steps = bsfa_pkg::STEP_W'(bsfa_pkg::TSUM_W);
            div_num       = r_tsum;
            div_den       = DVW'(r_total);
        end
    end

    bsfa_div #(
        .NUM_W (bsfa_pkg::TSUM_W),
        .DEN_W (DVW),
        .QUO_W (bsfa_pkg::ALPHA_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_rem   (div_rem),
        .o_quo   (div_quo)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (n_sel == '0) ? S_OUT : S_SUM_ON;
                end
            end
            S_SUM_ON:  n_state = S_SUM_OFF;
            S_SUM_OFF: n_state = last ? S_CHK : S_SUM_ON;
            S_CHK:     n_state = (r_total == '0) ? S_OUT : S_MOD;
            S_MOD: begin
                if (div_stat.done) begin
                    n_state = S_SRCH_ON;
                end
            end
            S_SRCH_ON: n_state = (r_local <= add_sum) ? S_OUT : S_SRCH_OFF;
            S_SRCH_OFF: begin
                if (r_local < add_sum) begin
                    n_state = S_DIST;
                end else begin
                    n_state = last ? S_OUT : S_SRCH_ON;
                end
            end
            S_DIST:  n_state = S_FADE;
            S_FADE:  n_state = S_FIX;
            S_FIX:   n_state = S_CMP;
            S_CMP:   n_state = d_ge_fade ? S_OUT : S_SCALE;
            S_SCALE: n_state = S_DIV;
            S_DIV: begin
                if (div_stat.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_k <= '0;
                r_n <= n_sel;
            end else if (r_state == S_CHK) begin
                r_k <= '0;
            end else if ((r_state == S_SUM_OFF && !last) ||
                         (r_state == S_SRCH_OFF && r_local >= add_sum && !last)) begin
                r_k <= r_k + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_tsum  <= bsfa_pkg::TSUM_W'(i_in.time_us)
                           + bsfa_pkg::TSUM_W'(r_start_delay);
                r_total <= '0;
                r_edge  <= '0;
                r_res   <= bsfa_pkg::FULL_ALPHA;
            end
            S_SUM_ON, S_SUM_OFF: r_total <= add_sum;
            S_MOD:     r_local <= div_rem[TW-1:0];
            S_SRCH_ON: r_edge <= add_sum;
            S_SRCH_OFF: begin
                if (r_local < add_sum) begin
                    r_e1 <= add_sum;
                end else begin
                    r_edge <= add_sum;
                end
            end
            S_DIST: begin
                r_d0 <= r_local - r_edge;
                r_d1 <= r_e1 - r_local;
            end
            S_FADE: begin
                r_d    <= (r_d0 < r_d1) ? r_d0 : r_d1;
                r_big  <= off_ext >= OW'(bsfa_pkg::OFF_SAT);
                r_prod <= PRW'(off_ext[bsfa_pkg::RECIP_W-1:0]) * PRW'(bsfa_pkg::RECIP10);
            end
            S_FIX: begin
                if (r_big) begin
                    r_fade <= bsfa_pkg::FADE_MAX;
                end else if (q10 < bsfa_pkg::FADE_MIN) begin
                    r_fade <= bsfa_pkg::FADE_MIN;
                end else begin
                    r_fade <= q10;
                end
            end
            S_CMP: begin
                r_res <= bsfa_pkg::ZERO_ALPHA;
                r_x   <= fade_diff[bsfa_pkg::FADE_W-1:0];
            end
            S_DIV: r_res <= div_quo;
            default: ;
        endcase
        if (out_load) begin
            r_alpha <= r_res;
            r_vis   <= r_res != bsfa_pkg::ZERO_ALPHA;
        end
    end

    assign i_in.ready    = r_state == S_IDLE;
    assign o_out.valid   = r_out_valid;
    assign o_out.alpha   = r_alpha;
    assign o_out.visible = r_vis;

`ifndef SYNTH
    a_div_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> (r_state == S_MOD || r_state == S_DIV))
        else $error("divider busy outside a divide step");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state != S_IDLE)
        else $error("accepted item did not start the sequencer");

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM_ON || r_state == S_SUM_OFF || r_state == S_SRCH_ON ||
         r_state == S_SRCH_OFF) |-> r_k < r_n)
        else $error("pair index beyond pair count");

    a_visible_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_vis == (r_alpha != bsfa_pkg::ZERO_ALPHA)))
        else $error("visible flag disagrees with alpha");

    a_out_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !o_out.ready) |=> r_state == S_OUT)
        else $error("result left the sequencer while the output was full");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_blink_sequence_fade_alpha.sv =====
`timescale 1ns / 100ps
// Self-checking bench for blink_sequence_fade_alpha: a directed part, then random
// register settings and times, with an internal alpha predictor and an item scoreboard.
// Depends on bsfa_pkg, bsfa_in_if, bsfa_out_if and the block itself.

module tb_blink_sequence_fade_alpha;

    localparam int DUR_W    = 24;
    localparam int CFG_W    = 2 * DUR_W;
    localparam int PI_W     = $clog2(bsfa_pkg::PAIR_REGS);
    localparam int IDLE_PCT = 35;
    localparam int LIMIT    = 1000000;
    localparam logic [bsfa_pkg::CFG_IDX_W-1:0] REG_SPARE =
        bsfa_pkg::CFG_IDX_W'(bsfa_pkg::REG_PAIR_ZERO + bsfa_pkg::PAIR_REGS);

    typedef struct packed {
        logic                        hold;
        logic [bsfa_pkg::TIME_W-1:0] t;
    } t_time_item;

    typedef struct packed {
        logic [bsfa_pkg::ALPHA_W-1:0] alpha;
        logic                         visible;
    } t_shade;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                             cfg_we;
    logic [bsfa_pkg::CFG_IDX_W-1:0]   cfg_idx;
    logic [CFG_W-1:0]                 cfg_data;

    bsfa_in_if  in_ch ();
    bsfa_out_if out_ch ();

    blink_sequence_fade_alpha u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // register mirror
    logic [2:0]         cfg_pair_count;
    logic [DUR_W-1:0]   cfg_delay;
    logic [CFG_W-1:0]   cfg_pair [bsfa_pkg::PAIR_REGS];

    t_time_item time_q [$];
    t_shade     shade_q [$];

    int unsigned n_queued, n_taken, n_checked, n_err, n_cycles, n_settings;
    int unsigned n_fading, n_dark, n_lit;
    bit          calm;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) n_cycles <= n_cycles + 1;

    function automatic logic [bsfa_pkg::ALPHA_W-1:0] fade_alpha(
            input logic [bsfa_pkg::TIME_W-1:0] t);
        int unsigned     n, k;
        longint unsigned total, pos, mark, on_t, off_t, e0, e1, d, fade, lvl, tl;
        n = (cfg_pair_count > bsfa_pkg::PAIR_REGS) ? bsfa_pkg::PAIR_REGS
                                                   : 32'(cfg_pair_count);
        total = 0;
        for (k = 0; k < n; k++)
            total += cfg_pair[k][DUR_W-1:0] + cfg_pair[k][CFG_W-1:DUR_W];
        if (n == 0 || total == 0)
            return bsfa_pkg::FULL_ALPHA;
        tl = t;
        pos = (tl + cfg_delay) % total;
        mark = 0;
        for (k = 0; k < n; k++) begin
            on_t  = cfg_pair[k][DUR_W-1:0];
            off_t = cfg_pair[k][CFG_W-1:DUR_W];
            e0 = mark + on_t;
            e1 = e0 + off_t;
            mark = e1;
            if (pos <= e0)
                return bsfa_pkg::FULL_ALPHA;
            if (pos < e1) begin
                d = (pos - e0 < e1 - pos) ? pos - e0 : e1 - pos;
                fade = off_t / 10;
                if (fade > bsfa_pkg::FADE_MAX) fade = bsfa_pkg::FADE_MAX;
                if (fade < bsfa_pkg::FADE_MIN) fade = bsfa_pkg::FADE_MIN;
                if (d >= fade)
                    return bsfa_pkg::ZERO_ALPHA;
                lvl = (bsfa_pkg::FULL_ALPHA * (fade - d)) / fade;
                return lvl[bsfa_pkg::ALPHA_W-1:0];
            end
        end
        return bsfa_pkg::FULL_ALPHA;
    endfunction

    // sender
    always @(posedge i_clk) begin : drv
        logic [bsfa_pkg::ALPHA_W-1:0] a;
        t_time_item                   nxt;
        if (!i_rst_n) begin
            in_ch.valid   <= 1'b0;
            in_ch.time_us <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                a = fade_alpha(in_ch.time_us);
                shade_q.push_back('{alpha: a, visible: (a != bsfa_pkg::ZERO_ALPHA)});
                n_taken++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (time_q.size() != 0 && !(time_q[0].hold && n_checked != n_taken)
                        && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt = time_q.pop_front();
                    in_ch.valid   <= 1'b1;
                    in_ch.time_us <= nxt.t;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin : mon
        t_shade want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (shade_q.size() == 0) begin
                    $display("%0t: unexpected item alpha=%0d visible=%0b", $time,
                             out_ch.alpha, out_ch.visible);
                    n_err++;
                end else begin
                    want = shade_q.pop_front();
                    n_checked++;
                    if (out_ch.alpha !== want.alpha) begin
                        $display("%0t: alpha expected %0d actual %0d", $time,
                                 want.alpha, out_ch.alpha);
                        n_err++;
                    end
                    if (out_ch.visible !== want.visible) begin
                        $display("%0t: visible expected %0b actual %0b", $time,
                                 want.visible, out_ch.visible);
                        n_err++;
                    end
                    if (want.alpha == bsfa_pkg::ZERO_ALPHA)      n_dark++;
                    else if (want.alpha == bsfa_pkg::FULL_ALPHA) n_lit++;
                    else                                         n_fading++;
                end
            end
            out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic write_reg(input logic [bsfa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == bsfa_pkg::REG_PAIR_COUNT)
            cfg_pair_count = data[2:0];
        else if (idx == bsfa_pkg::REG_START_DELAY)
            cfg_delay = data[DUR_W-1:0];
        else if (idx >= bsfa_pkg::REG_PAIR_ZERO && idx < REG_SPARE)
            cfg_pair[PI_W'(idx - bsfa_pkg::REG_PAIR_ZERO)] = data;
    endtask

    task automatic set_pair(input int unsigned k, input logic [DUR_W-1:0] on_t,
                            input logic [DUR_W-1:0] off_t);
        logic [bsfa_pkg::CFG_IDX_W-1:0] idx;
        idx = bsfa_pkg::REG_PAIR_ZERO + bsfa_pkg::CFG_IDX_W'(k);
        write_reg(idx, {off_t, on_t});
    endtask

    task automatic push_time(input logic [bsfa_pkg::TIME_W-1:0] t, input logic hold);
        time_q.push_back('{hold: hold, t: t});
        n_queued++;
    endtask

    task automatic settle();
        while (n_taken != n_queued || n_checked != n_taken)
            @(posedge i_clk);
        n_settings++;
    endtask

    function automatic logic [bsfa_pkg::TIME_W-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom, $urandom};
        if ($urandom_range(3) == 0)
            r = r >> $urandom_range(0, bsfa_pkg::TIME_W - 1);
        return r[bsfa_pkg::TIME_W-1:0];
    endfunction

    function automatic logic [DUR_W-1:0] rand_dur();
        logic [31:0] r;
        case ($urandom_range(3))
            0:       r = $urandom_range(0, 300);
            1:       r = $urandom_range(0, 50000);
            2:       r = $urandom_range(0, 3000000);
            default: r = $urandom;
        endcase
        return r[DUR_W-1:0];
    endfunction

    // time that lands close to one phase edge of the current sequence
    function automatic logic [bsfa_pkg::TIME_W-1:0] near_edge_time();
        longint unsigned marks [2*bsfa_pkg::PAIR_REGS];
        longint unsigned total, mark, w, off, target, tt;
        int unsigned     n, k, m;
        n = (cfg_pair_count > bsfa_pkg::PAIR_REGS) ? bsfa_pkg::PAIR_REGS
                                                   : 32'(cfg_pair_count);
        total = 0;
        mark = 0;
        for (k = 0; k < n; k++) begin
            mark += cfg_pair[k][DUR_W-1:0];
            marks[2*k] = mark;
            mark += cfg_pair[k][CFG_W-1:DUR_W];
            marks[2*k+1] = mark;
        end
        total = mark;
        if (total == 0)
            return rand_time();
        m = $urandom_range(0, 2*n - 1);
        case ($urandom_range(2))
            0:       w = 3;
            1:       w = 300;
            default: w = 150000;
        endcase
        off = $urandom_range(0, 32'(2*w));
        target = (marks[m] + off + (w / total + 1) * total - w) % total;
        tt = total * $urandom_range(0, 1 << 20)
             + (target + total - (cfg_delay % total)) % total;
        return tt[bsfa_pkg::TIME_W-1:0];
    endfunction

    task automatic random_phase(input int unsigned n_items);
        logic [CFG_W-1:0]               data;
        logic [bsfa_pkg::CFG_IDX_W-1:0] idx;
        int unsigned                    k, r;
        data = CFG_W'({$urandom, $urandom});
        data[2:0] = ($urandom_range(9) < 8) ? 3'($urandom_range(1, 4))
                                            : 3'($urandom_range(0, 7));
        write_reg(bsfa_pkg::REG_PAIR_COUNT, data);
        data = CFG_W'({$urandom, $urandom});
        case ($urandom_range(3))
            0:       data[DUR_W-1:0] = '0;
            1:       data[DUR_W-1:0] = '1;
            default: ;
        endcase
        write_reg(bsfa_pkg::REG_START_DELAY, data);
        for (k = 0; k < bsfa_pkg::PAIR_REGS; k++) begin
            if ($urandom_range(9) < 7) begin
                idx = bsfa_pkg::REG_PAIR_ZERO + bsfa_pkg::CFG_IDX_W'(k);
                write_reg(idx, {rand_dur(), rand_dur()});
            end
        end
        for (k = 0; k < n_items; k++) begin
            r = $urandom_range(99);
            push_time((r < 75) ? near_edge_time() : rand_time(), r < 2);
        end
        settle();
    endtask

    initial begin : wdog
        while (n_cycles < LIMIT)
            @(posedge i_clk);
        $display("timeout after %0d cycles", n_cycles);
        $display("tb_blink_sequence_fade_alpha: done, errors");
        $finish;
    end

    initial begin : stim
        int unsigned k;
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_data        = '0;
        cfg_pair_count  = '0;
        cfg_delay       = '0;
        for (k = 0; k < bsfa_pkg::PAIR_REGS; k++)
            cfg_pair[k] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: steady light
        push_time('0, 1'b0);
        push_time('1, 1'b0);
        settle();

        // one pair, minimum fade of 100 us around a 1000 us off phase
        write_reg(bsfa_pkg::REG_PAIR_COUNT, 48'd1);
        set_pair(0, 24'd1000, 24'd1000);
        push_time(48'd0, 1'b0);
        push_time(48'd1000, 1'b0);
        push_time(48'd1001, 1'b0);
        push_time(48'd1050, 1'b0);
        push_time(48'd1099, 1'b0);
        push_time(48'd1100, 1'b0);
        push_time(48'd1500, 1'b1);
        push_time(48'd1999, 1'b0);
        push_time(48'd2000, 1'b0);
        settle();

        // spare indexes must not disturb anything
        write_reg(REG_SPARE, '1);
        write_reg(REG_SPARE + 3'd1, '1);
        push_time(48'd1050, 1'b0);
        push_time(48'd1500, 1'b0);
        settle();

        // oversized count, all durations and delay at maximum, fade clamped high
        write_reg(bsfa_pkg::REG_PAIR_COUNT, '1);
        write_reg(bsfa_pkg::REG_START_DELAY, '1);
        for (k = 0; k < bsfa_pkg::PAIR_REGS; k++)
            set_pair(k, '1, '1);
        push_time('1, 1'b0);
        push_time('0, 1'b0);
        push_time(48'd1, 1'b0);
        push_time(48'd50001, 1'b0);
        settle();

        // zero total: only the unused pair has durations
        write_reg(bsfa_pkg::REG_PAIR_COUNT, 48'd3);
        write_reg(bsfa_pkg::REG_START_DELAY, 48'd0);
        for (k = 0; k < 3; k++)
            set_pair(k, '0, '0);
        set_pair(3, 24'd7, 24'd9);
        push_time(rand_time(), 1'b0);
        push_time(48'd0, 1'b0);
        settle();

        // zero on time with a tiny off phase
        write_reg(bsfa_pkg::REG_PAIR_COUNT, 48'd1);
        set_pair(0, 24'd0, 24'd5);
        for (k = 0; k < 4; k++)
            push_time(bsfa_pkg::TIME_W'(k), 1'b0);
        settle();

        for (k = 0; k < 11; k++) begin
            calm = (k == 5);
            random_phase(110);
        end
        calm = 1'b0;

        repeat (150) @(posedge i_clk);
        $display("%0d items checked over %0d register settings", n_checked, n_settings);
        $display("results: %0d fading, %0d dark, %0d fully lit", n_fading, n_dark, n_lit);
        if (n_err == 0)
            $display("tb_blink_sequence_fade_alpha: done, clean");
        else
            $display("tb_blink_sequence_fade_alpha: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/bsfa_pkg.sv
sv/bsfa_in_if.sv
sv/bsfa_out_if.sv
sv/bsfa_div.sv
sv/blink_sequence_fade_alpha.sv
tb/sv/tb_blink_sequence_fade_alpha.sv
